// File: rtl/i2cms_pkg.sv
// Package with shared types, status codes and widths of the I2C transfer sequencer.
`timescale 1ns / 1ps
package i2cms_pkg;
	localparam int MaxMessagesDef = 16;
	localparam int LengthBitsDef  = 16;
	localparam int BytesBits      = 20;

	localparam logic [1:0] FuncLoad  = 2'd0;
	localparam logic [1:0] FuncStart = 2'd1;
	localparam logic [1:0] FuncEvent = 2'd2;

	localparam logic [1:0] ResBusy    = 2'd0;
	localparam logic [1:0] ResOk      = 2'd1;
	localparam logic [1:0] ResIoErr   = 2'd2;
	localparam logic [1:0] ResInvalid = 2'd3;

	localparam logic [7:0] StBusErr    = 8'h00;
	localparam logic [7:0] StStart     = 8'h08;
	localparam logic [7:0] StRepStart  = 8'h10;
	localparam logic [7:0] StAwAck     = 8'h18;
	localparam logic [7:0] StAwNack    = 8'h20;
	localparam logic [7:0] StDwAck     = 8'h28;
	localparam logic [7:0] StDwNack    = 8'h30;
	localparam logic [7:0] StArAck     = 8'h40;
	localparam logic [7:0] StArNack    = 8'h48;
	localparam logic [7:0] StDrAck     = 8'h50;
	localparam logic [7:0] StDrNack    = 8'h58;
	localparam logic [7:0] StIdle      = 8'hF8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_desc;     // write the descriptor table
		logic rd_desc;     // read table at scan index
		logic grp_init;    // latch head from read data, begin sum
		logic grp_add;     // add read data to sum, bump end index
		logic set_total;   // latch message total
		logic dec_bytes;   // count one byte
		logic set_scan;    // scan index := group end index
		logic clr_scan;    // scan index := 0
		logic inc_scan;    // scan index + 1
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       rd_ns;
		logic       rd_rd;
		logic       head_rd;
		logic       scan_in;      // scan index < total and < max
		logic       bytes_zero;
		logic       bytes_gt1;
		logic       bytes_one;
		logic [7:0] addr_byte;
	} dp_stat_t;
endpackage

// File: rtl/i2cms_datapath.sv
// Datapath of the I2C transfer sequencer: descriptor memory, group registers, byte count.
`timescale 1ns / 1ps
module i2cms_datapath import i2cms_pkg::*; #(
	parameter int MAX_MESSAGES = MaxMessagesDef,
	parameter int LENGTH_BITS  = LengthBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [3:0]           desc_index,
	input  logic [6:0]           dev_addr,
	input  logic                 read_flag,
	input  logic                 nostart_flag,
	input  logic [15:0]          length,
	input  logic [4:0]           num_msgs,
	output dp_stat_t             stat
);
	localparam int IdxW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
	localparam int CntW = $clog2(MAX_MESSAGES + 1) + 1;
	localparam int EntW = 9 + LENGTH_BITS;
	localparam logic [BytesBits-1:0] BytesMax = '1;

	logic [EntW-1:0] mem [MAX_MESSAGES];
	logic [EntW-1:0] rdata_q;
	logic [CntW-1:0] scan_q, end_q, total_q;
	logic [7:0]      head_addr_q;
	logic            head_rd_q;
	logic [BytesBits-1:0] bytes_q;
	logic [BytesBits:0]   sum;
	logic [LENGTH_BITS-1:0] rlen;

	assign rlen = rdata_q[LENGTH_BITS-1:0];
	assign sum  = {1'b0, bytes_q} + {{(BytesBits + 1 - LENGTH_BITS){1'b0}}, rlen};

	always_ff @(posedge clk) begin
		if (cmd.wr_desc && (32'(desc_index) < 32'(MAX_MESSAGES)))
			mem[IdxW'(desc_index)] <= {dev_addr, read_flag, nostart_flag,
				length[LENGTH_BITS-1:0]};
		if (cmd.rd_desc)
			rdata_q <= mem[scan_q[IdxW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0; end_q <= '0; total_q <= '0;
			bytes_q <= '0; head_addr_q <= '0; head_rd_q <= 1'b0;
		end else begin
			if (cmd.set_total) total_q <= CntW'(num_msgs);
			if (cmd.clr_scan) scan_q <= '0;
			else if (cmd.set_scan) scan_q <= end_q;
			else if (cmd.inc_scan) scan_q <= scan_q + 1'b1;
			if (cmd.grp_init) begin
				head_addr_q <= {rdata_q[EntW-1 -: 7], rdata_q[EntW-8]};
				head_rd_q   <= rdata_q[EntW-8];
				bytes_q     <= BytesBits'(rlen);
				end_q       <= scan_q + 1'b1;
			end else if (cmd.grp_add) begin
				bytes_q <= sum[BytesBits] ? BytesMax : sum[BytesBits-1:0];
				end_q   <= scan_q + 1'b1;
			end else if (cmd.dec_bytes) begin
				bytes_q <= bytes_q - 1'b1;
			end
		end
	end

	always_comb begin
		stat.rd_ns      = rdata_q[LENGTH_BITS];
		stat.rd_rd      = rdata_q[LENGTH_BITS+1];
		stat.head_rd    = head_rd_q;
		stat.scan_in    = (scan_q < total_q) && (scan_q < CntW'(MAX_MESSAGES));
		stat.bytes_zero = (bytes_q == '0);
		stat.bytes_one  = (bytes_q == BytesBits'(1));
		stat.bytes_gt1  = (bytes_q > BytesBits'(1));
		stat.addr_byte  = head_addr_q;
	end
endmodule

// File: rtl/i2cms_ctrl.sv
// Controller state machine of the I2C transfer sequencer.
`timescale 1ns / 1ps
module i2cms_ctrl import i2cms_pkg::*; #(
	parameter int MAX_MESSAGES = MaxMessagesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [4:0] num_msgs,
	input  logic [7:0] stat_code,
	input  logic [7:0] rx_byte,
	input  logic [7:0] tx_byte,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       done,
	output logic       bus_start,
	output logic       bus_stop,
	output logic       ack_set,
	output logic       ack_clear,
	output logic       start_clear,
	output logic       irq_clear,
	output logic       data_write,
	output logic [7:0] data_out,
	output logic       tx_taken,
	output logic       rx_valid,
	output logic [7:0] rx_data,
	output logic [1:0] result_code
);
	typedef enum logic [2:0] {
		S_IDLE, S_RD0, S_HEAD, S_SCAN_RD, S_SCAN, S_ADV_RD, S_ADV, S_FIN
	} state_t;

	state_t state_q;
	logic   active_q;
	logic   adv_q;      // grouping started by an advance, not a start item

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		if (state_q == S_IDLE && start) begin
			cmd.wr_desc   = (func == FuncLoad);
			cmd.set_total = (func == FuncStart) && (num_msgs != 5'd0) &&
				(32'(num_msgs) <= 32'(MAX_MESSAGES));
			cmd.clr_scan  = (func == FuncStart);
		end
		case (state_q)
			S_RD0:     cmd.rd_desc = 1'b1;
			S_ADV_RD:  cmd.rd_desc = 1'b1;
			S_HEAD:    begin cmd.grp_init = 1'b1; cmd.inc_scan = 1'b1; end
			S_SCAN_RD: cmd.rd_desc = stat.scan_in;
			S_SCAN:    if (stat.rd_ns && stat.rd_rd == stat.head_rd) begin
				cmd.grp_add = 1'b1; cmd.inc_scan = 1'b1;
			end
			default:   ;
		endcase
		if (state_q == S_IDLE && start && func == FuncEvent && active_q) begin
			case (stat_code)
				StAwAck, StDwAck: cmd.dec_bytes = !stat.bytes_zero;
				StDrAck, StDrNack: cmd.dec_bytes = !stat.bytes_zero;
				default: ;
			endcase
			cmd.set_scan = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; active_q <= 1'b0; adv_q <= 1'b0;
			done <= 1'b0; bus_start <= 1'b0; bus_stop <= 1'b0; ack_set <= 1'b0;
			ack_clear <= 1'b0; start_clear <= 1'b0; irq_clear <= 1'b0;
			data_write <= 1'b0; data_out <= '0; tx_taken <= 1'b0;
			rx_valid <= 1'b0; rx_data <= '0; result_code <= ResBusy;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					bus_start <= 1'b0; bus_stop <= 1'b0; ack_set <= 1'b0;
					ack_clear <= 1'b0; start_clear <= 1'b0; irq_clear <= 1'b0;
					data_write <= 1'b0; data_out <= '0; tx_taken <= 1'b0;
					rx_valid <= 1'b0; rx_data <= '0; result_code <= ResBusy;
					case (func)
						FuncStart: begin
							active_q <= 1'b0;
							if (num_msgs == 5'd0) begin
								result_code <= ResOk; done <= 1'b1;
							end else if (32'(num_msgs) > 32'(MAX_MESSAGES)) begin
								result_code <= ResInvalid; done <= 1'b1;
							end else begin
								adv_q <= 1'b0; state_q <= S_RD0;
							end
						end
						FuncEvent: if (!active_q) begin
							done <= 1'b1;
						end else begin
							done <= 1'b1;
							case (stat_code)
								StBusErr, StAwNack, StArNack: begin
									bus_stop <= 1'b1; ack_set <= 1'b1; irq_clear <= 1'b1;
									result_code <= ResIoErr; active_q <= 1'b0;
								end
								StStart, StRepStart: begin
									data_write <= 1'b1; data_out <= stat.addr_byte;
									ack_set <= 1'b1; start_clear <= 1'b1; irq_clear <= 1'b1;
								end
								StAwAck, StDwAck: if (!stat.bytes_zero) begin
									data_write <= 1'b1; data_out <= tx_byte; tx_taken <= 1'b1;
									ack_set <= 1'b1; irq_clear <= 1'b1;
								end else begin
									done <= 1'b0; state_q <= S_ADV_RD;
								end
								StDwNack: if (stat.bytes_zero) begin
									done <= 1'b0; state_q <= S_ADV_RD;
								end else begin
									bus_stop <= 1'b1; irq_clear <= 1'b1;
									result_code <= ResIoErr; active_q <= 1'b0;
								end
								StArAck: begin
									irq_clear <= 1'b1;
									if (stat.bytes_gt1) ack_set <= 1'b1;
									else ack_clear <= 1'b1;
								end
								StDrAck, StDrNack: begin
									if (!stat.bytes_zero) begin
										rx_valid <= 1'b1; rx_data <= rx_byte;
									end
									// Count before the decrement of this event.
									if (stat.bytes_gt1 && !(stat.bytes_zero) &&
										!(stat.bytes_one)) begin
										if ((stat.bytes_gt1) && !(stat.bytes_one)) begin
											irq_clear <= 1'b1;
											state_q <= S_FIN; done <= 1'b0;
										end
									end else if (stat.bytes_one) begin
										done <= 1'b0; state_q <= S_ADV_RD;
									end else begin
										done <= 1'b0; state_q <= S_ADV_RD;
									end
								end
								StIdle: ;
								default: begin
									result_code <= ResIoErr; active_q <= 1'b0;
								end
							endcase
						end
						default: done <= 1'b1;
					endcase
				end
				S_FIN: begin
					// Read data phase with more than one byte before the count:
					// the decremented count decides ack or nack.
					if (stat.bytes_gt1) ack_set <= 1'b1;
					else ack_clear <= 1'b1;
					done <= 1'b1; state_q <= S_IDLE;
				end
				S_RD0: state_q <= S_HEAD;
				S_HEAD: begin
					if (!adv_q) begin
						if (stat.rd_ns) begin
							result_code <= ResInvalid; done <= 1'b1; state_q <= S_IDLE;
						end else state_q <= S_SCAN_RD;
					end else state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: state_q <= stat.scan_in ? S_SCAN : S_FIN;
				S_SCAN: state_q <= (stat.rd_ns && stat.rd_rd == stat.head_rd) ?
					S_SCAN_RD : S_FIN;
				S_ADV_RD: begin
					irq_clear <= 1'b1;
					if (stat.scan_in) state_q <= S_ADV;
					else begin
						bus_stop <= 1'b1; result_code <= ResOk; active_q <= 1'b0;
						done <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_ADV: begin
					if (stat.rd_ns) begin
						bus_stop <= 1'b1; result_code <= ResInvalid; active_q <= 1'b0;
					end else bus_start <= 1'b1;
					adv_q <= 1'b1; state_q <= S_HEAD;
				end
				default: state_q <= S_IDLE;
			endcase
			// Group scan ends here and returns to S_IDLE; finish the start item or the advance.
			if ((state_q == S_SCAN_RD && !stat.scan_in) ||
				(state_q == S_SCAN && !(stat.rd_ns && stat.rd_rd == stat.head_rd))) begin
				state_q <= S_IDLE; done <= 1'b1;
				if (!adv_q) begin
					bus_start <= 1'b1; active_q <= 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(bus_start && bus_stop && result_code == ResBusy))
		else $error("start and stop requested together on a running transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_code != ResBusy) |-> !active_q)
		else $error("final code given while transfer still active");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && tx_taken) |-> data_write)
		else $error("host byte taken without a data write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (done || busy))
		else $error("accepted word neither answered nor in progress");
endmodule

// File: rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: controller plus datapath.
`timescale 1ns / 1ps
// Load, idle, unknown and most event words answer directly from S_IDLE; a data-received
// event with more than one byte left answers through S_FIN. A start word reads the new
// group (S_RD0, S_HEAD, then S_SCAN_RD and S_SCAN per message) and stops in S_HEAD if
// the first message lacks a start; an event that ends a group answers from S_ADV_RD when none
// is left, else it also scans the next group. One word at a time (busy high meanwhile); the receiver
// cannot stall. Reset (arst_n low) ends any transfer; the descriptor table stays undefined.
module i2c_master_transfer_sequencer import i2cms_pkg::*; #(
	parameter int MAX_MESSAGES = MaxMessagesDef,
	parameter int LENGTH_BITS  = LengthBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  func,
	input  logic [3:0]  desc_index,
	input  logic [6:0]  dev_addr,
	input  logic        read_flag,
	input  logic        nostart_flag,
	input  logic [15:0] length,
	input  logic [4:0]  num_msgs,
	input  logic [7:0]  stat_code,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  tx_byte,
	output logic        bus_start,
	output logic        bus_stop,
	output logic        ack_set,
	output logic        ack_clear,
	output logic        start_clear,
	output logic        irq_clear,
	output logic        data_write,
	output logic [7:0]  data_out,
	output logic        tx_taken,
	output logic        rx_valid,
	output logic [7:0]  rx_data,
	output logic [1:0]  result_code
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The datapath keeps the descriptor memory and the current group.
	i2cms_datapath #(.MAX_MESSAGES(MAX_MESSAGES), .LENGTH_BITS(LENGTH_BITS)) u_dp (
		.clk, .arst_n, .cmd, .desc_index, .dev_addr, .read_flag, .nostart_flag,
		.length, .num_msgs, .stat
	);

	// The controller decodes each word and sequences group scans.
	i2cms_ctrl #(.MAX_MESSAGES(MAX_MESSAGES)) u_ctrl (
		.clk, .arst_n, .start, .busy, .func, .num_msgs, .stat_code, .rx_byte,
		.tx_byte, .stat, .cmd, .done, .bus_start, .bus_stop, .ack_set,
		.ack_clear, .start_clear, .irq_clear, .data_write, .data_out, .tx_taken,
		.rx_valid, .rx_data, .result_code
	);
endmodule
